// ===== hw/rtl/bgcg_pkg.sv =====
// Shared types, constants and lookup functions for the bitmap glyph cell generator.
// Used by every module under hw/rtl except bgcg_ram; depends on nothing else.

package bgcg_pkg;

   // Geometry and storage
   localparam int TABLE_DEPTH  = 32;
   localparam int NARROW_WIDTH = 3;
   localparam int WIDE_WIDTH   = 4;
   localparam int LINE_HEIGHT  = 6;
   localparam int COORD_BITS   = 10;

   localparam int GLYPH_ROWS   = 5;
   localparam int MAX_SCAN     = 20;
   localparam int ENTRY_BITS   = 22;
   localparam int ENTRY_NARROW = 21;
   localparam int ENTRY_DIAG   = 20;
   localparam int ADDR_BITS    = $clog2(TABLE_DEPTH);

   localparam int MAX_WIDTH = (NARROW_WIDTH > WIDE_WIDTH) ? NARROW_WIDTH : WIDE_WIDTH;
   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int ROW_BITS  = $clog2(GLYPH_ROWS);
   localparam int DELTA_BITS = 5;

   localparam int CELLS_NARROW = (NARROW_WIDTH * GLYPH_ROWS > MAX_SCAN) ?
                                 MAX_SCAN : NARROW_WIDTH * GLYPH_ROWS;
   localparam int CELLS_WIDE   = (WIDE_WIDTH * GLYPH_ROWS > MAX_SCAN) ?
                                 MAX_SCAN : WIDE_WIDTH * GLYPH_ROWS;
   localparam int SHIFT_NARROW = MAX_SCAN - CELLS_NARROW;
   localparam int SHIFT_WIDE   = MAX_SCAN - CELLS_WIDE;

   // Request payload layout
   localparam int REQ_DATA_BITS = 40;
   localparam int REQ_CHAR_LO   = 0;
   localparam int REQ_INDEX_LO  = 8;
   localparam int REQ_NARROW    = 13;
   localparam int REQ_DIAG      = 14;
   localparam int REQ_BITMAP_LO = 15;

   // Response payload layout
   localparam int RSP_FIELD_BITS = 2 * COORD_BITS + 2;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // Character codes
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_BANG    = 8'h21;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_QUEST   = 8'h3F;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   localparam logic [4:0] SLOT_BANG  = 5'd26;
   localparam logic [4:0] SLOT_DOT   = 5'd27;
   localparam logic [4:0] SLOT_QUEST = 5'd28;

   // Letter indexes that carry diagonal pieces
   localparam logic [4:0] LTR_B = 5'd1;
   localparam logic [4:0] LTR_D = 5'd3;
   localparam logic [4:0] LTR_G = 5'd6;
   localparam logic [4:0] LTR_J = 5'd9;
   localparam logic [4:0] LTR_K = 5'd10;
   localparam logic [4:0] LTR_N = 5'd13;
   localparam logic [4:0] LTR_P = 5'd15;
   localparam logic [4:0] LTR_Q = 5'd16;
   localparam logic [4:0] LTR_R = 5'd17;
   localparam logic [4:0] LTR_S = 5'd18;

   localparam int DIAG_BITS = 5;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_DRAW    = 2'd1,
      CMD_RESTART = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_FULL = 2'd0,
      KIND_LL   = 2'd1,
      KIND_UR   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      CHR_NONE,
      CHR_LETTER,
      CHR_BANG,
      CHR_DOT,
      CHR_QUEST,
      CHR_SPACE,
      CHR_NEWLINE
   } chr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SCAN,
      ST_DIAG,
      ST_CURSOR
   } state_type;

   // Request handed from the front end to the sequencer
   typedef struct packed {
      logic       start;
      logic       restart;
      chr_type    chr;
      logic [4:0] letter;
   } seq_req_type;

   typedef struct packed {
      logic [2:0] dx;
      logic [2:0] dy;
      kind_type   kind;
   } diag_type;

   typedef struct packed {
      logic [DIAG_BITS-1:0] start;
      logic [2:0]           count;
   } diag_range_type;

   function automatic diag_type diag_piece(input logic [DIAG_BITS-1:0] idx);
      diag_type p;
      p = '{dx: 3'd0, dy: 3'd0, kind: KIND_FULL};
      unique case (idx)
         5'd0:  p = '{dx: 3'd2, dy: 3'd0, kind: KIND_LL};
         5'd1:  p = '{dx: 3'd2, dy: 3'd0, kind: KIND_LL};
         5'd2:  p = '{dx: 3'd2, dy: 3'd2, kind: KIND_LL};
         5'd3:  p = '{dx: 3'd0, dy: 3'd4, kind: KIND_UR};
         5'd4:  p = '{dx: 3'd2, dy: 3'd3, kind: KIND_LL};
         5'd5:  p = '{dx: 3'd1, dy: 3'd3, kind: KIND_UR};
         5'd6:  p = '{dx: 3'd1, dy: 3'd0, kind: KIND_LL};
         5'd7:  p = '{dx: 3'd1, dy: 3'd1, kind: KIND_UR};
         5'd8:  p = '{dx: 3'd2, dy: 3'd1, kind: KIND_LL};
         5'd9:  p = '{dx: 3'd2, dy: 3'd2, kind: KIND_UR};
         5'd10: p = '{dx: 3'd2, dy: 3'd0, kind: KIND_LL};
         5'd11: p = '{dx: 3'd2, dy: 3'd0, kind: KIND_LL};
         5'd12: p = '{dx: 3'd0, dy: 3'd4, kind: KIND_UR};
         5'd13: p = '{dx: 3'd2, dy: 3'd3, kind: KIND_LL};
         5'd14: p = '{dx: 3'd1, dy: 3'd3, kind: KIND_UR};
         5'd15: p = '{dx: 3'd1, dy: 3'd1, kind: KIND_LL};
         5'd16: p = '{dx: 3'd0, dy: 3'd2, kind: KIND_UR};
         5'd17: p = '{dx: 3'd2, dy: 3'd2, kind: KIND_LL};
         5'd18: p = '{dx: 3'd1, dy: 3'd3, kind: KIND_UR};
         default: p = '{dx: 3'd0, dy: 3'd0, kind: KIND_FULL};
      endcase
      return p;
   endfunction

   function automatic diag_range_type diag_range(input logic [4:0] letter);
      diag_range_type r;
      r = '{start: 5'd0, count: 3'd0};
      unique case (letter)
         LTR_B: r = '{start: 5'd0,  count: 3'd1};
         LTR_D: r = '{start: 5'd1,  count: 3'd1};
         LTR_G: r = '{start: 5'd2,  count: 3'd1};
         LTR_J: r = '{start: 5'd3,  count: 3'd1};
         LTR_K: r = '{start: 5'd4,  count: 3'd2};
         LTR_N: r = '{start: 5'd6,  count: 3'd4};
         LTR_P: r = '{start: 5'd10, count: 3'd1};
         LTR_Q: r = '{start: 5'd11, count: 3'd2};
         LTR_R: r = '{start: 5'd13, count: 3'd2};
         LTR_S: r = '{start: 5'd15, count: 3'd4};
         default: r = '{start: 5'd0, count: 3'd0};
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/bgcg_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; holds the glyph table.

module bgcg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bgcg_sat_unit.sv =====
// Shared saturating adder for cell coordinates and cursor moves.
// Depends on bgcg_pkg.

module bgcg_sat_unit (
   input  logic [bgcg_pkg::COORD_BITS-1:0] base_col,
   input  logic [bgcg_pkg::COORD_BITS-1:0] base_row,
   input  logic [bgcg_pkg::DELTA_BITS-1:0] dx,
   input  logic [bgcg_pkg::DELTA_BITS-1:0] dy,
   output logic [bgcg_pkg::COORD_BITS-1:0] sum_col,
   output logic [bgcg_pkg::COORD_BITS-1:0] sum_row
);

   localparam int W = bgcg_pkg::COORD_BITS;

   logic [W:0] col_wide;
   logic [W:0] row_wide;

   assign col_wide = {1'b0, base_col} + (W+1)'(dx);
   assign row_wide = {1'b0, base_row} + (W+1)'(dy);

   // Clamp on carry out
   assign sum_col = col_wide[W] ? '1 : col_wide[W-1:0];
   assign sum_row = row_wide[W] ? '1 : row_wide[W-1:0];

endmodule

// ===== hw/rtl/bgcg_seq.sv =====
// Sequencer: bitmap scan, diagonal pieces, cursor update and response register.
// Depends on bgcg_pkg and bgcg_sat_unit.

module bgcg_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  bgcg_pkg::seq_req_type               req,
   input  logic [bgcg_pkg::ENTRY_BITS-1:0]     entry,
   output logic                                idle,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bgcg_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                                rsp_tlast
);

   localparam int CB = bgcg_pkg::COORD_BITS;
   localparam int DB = bgcg_pkg::DELTA_BITS;
   localparam int MS = bgcg_pkg::MAX_SCAN;

   bgcg_pkg::state_type state_ff, state_in;
   bgcg_pkg::chr_type   chr_ff, chr_in;
   logic [4:0]                       letter_ff, letter_in;
   logic [MS-1:0]                    sh_ff, sh_in;
   logic [bgcg_pkg::COL_BITS-1:0]    col_ff, col_in;
   logic [bgcg_pkg::COL_BITS-1:0]    last_col_ff, last_col_in;
   logic [bgcg_pkg::ROW_BITS-1:0]    row_ff, row_in;
   logic                             has_diag_ff, has_diag_in;
   logic [bgcg_pkg::DIAG_BITS-1:0]   diag_idx_ff, diag_idx_in;
   logic [bgcg_pkg::DIAG_BITS-1:0]   diag_end_ff, diag_end_in;
   logic [DB-1:0]                    adv_ff, adv_in;
   logic                             newline_ff, newline_in;
   logic [CB-1:0]                    cursor_col_ff, cursor_col_in;
   logic [CB-1:0]                    cursor_row_ff, cursor_row_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [CB-1:0]                    rsp_x_ff, rsp_x_in;
   logic [CB-1:0]                    rsp_y_ff, rsp_y_in;
   bgcg_pkg::kind_type               rsp_kind_ff, rsp_kind_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic [CB-1:0] unit_base_col, unit_base_row, unit_sum_col, unit_sum_row;
   logic [DB-1:0] unit_dx, unit_dy;

   logic                     emit, emit_last, out_free;
   bgcg_pkg::kind_type       emit_kind;
   logic                     narrow, glyph, scan_bit, rest_zero;
   logic [MS-1:0]            bitmap;
   bgcg_pkg::diag_range_type range;
   bgcg_pkg::diag_type       piece;

   bgcg_sat_unit u_sat (
      .base_col (unit_base_col),
      .base_row (unit_base_row),
      .dx       (unit_dx),
      .dy       (unit_dy),
      .sum_col  (unit_sum_col),
      .sum_row  (unit_sum_row)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bgcg_pkg::ST_IDLE;
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chr_ff      <= chr_in;
      letter_ff   <= letter_in;
      sh_ff       <= sh_in;
      col_ff      <= col_in;
      last_col_ff <= last_col_in;
      row_ff      <= row_in;
      has_diag_ff <= has_diag_in;
      diag_idx_ff <= diag_idx_in;
      diag_end_ff <= diag_end_in;
      adv_ff      <= adv_in;
      newline_ff  <= newline_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      chr_in        = chr_ff;
      letter_in     = letter_ff;
      sh_in         = sh_ff;
      col_in        = col_ff;
      last_col_in   = last_col_ff;
      row_in        = row_ff;
      has_diag_in   = has_diag_ff;
      diag_idx_in   = diag_idx_ff;
      diag_end_in   = diag_end_ff;
      adv_in        = adv_ff;
      newline_in    = newline_ff;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;

      unit_base_col = cursor_col_ff;
      unit_base_row = cursor_row_ff;
      unit_dx       = '0;
      unit_dy       = '0;

      emit      = 1'b0;
      emit_last = 1'b0;
      emit_kind = bgcg_pkg::KIND_FULL;
      out_free  = !rsp_valid_ff || rsp_tready;

      narrow    = (chr_ff == bgcg_pkg::CHR_LETTER) ? entry[bgcg_pkg::ENTRY_NARROW] : 1'b1;
      glyph     = (chr_ff == bgcg_pkg::CHR_LETTER) || (chr_ff == bgcg_pkg::CHR_BANG) ||
                  (chr_ff == bgcg_pkg::CHR_DOT) || (chr_ff == bgcg_pkg::CHR_QUEST);
      bitmap    = entry[MS-1:0];
      range     = bgcg_pkg::diag_range(letter_ff);
      piece     = bgcg_pkg::diag_piece(diag_idx_ff);
      scan_bit  = sh_ff[MS-1];
      rest_zero = (sh_ff[MS-2:0] == '0);

      unique case (state_ff)
         bgcg_pkg::ST_IDLE: begin
            if (req.restart) begin
               cursor_col_in = '0;
               cursor_row_in = '0;
            end
            if (req.start) begin
               chr_in    = req.chr;
               letter_in = req.letter;
               state_in  = bgcg_pkg::ST_FETCH;
            end
         end

         bgcg_pkg::ST_FETCH: begin
            // Align the used bitmap bits so the top-left cell sits in the MSB
            if (!glyph) begin
               sh_in = '0;
            end else if (narrow) begin
               sh_in = bitmap << bgcg_pkg::SHIFT_NARROW;
            end else begin
               sh_in = bitmap << bgcg_pkg::SHIFT_WIDE;
            end
            last_col_in = narrow ? bgcg_pkg::COL_BITS'(bgcg_pkg::NARROW_WIDTH - 1) :
                                   bgcg_pkg::COL_BITS'(bgcg_pkg::WIDE_WIDTH - 1);
            col_in      = '0;
            row_in      = '0;
            has_diag_in = (chr_ff == bgcg_pkg::CHR_LETTER) && entry[bgcg_pkg::ENTRY_DIAG] &&
                          (range.count != 3'd0);
            diag_idx_in = range.start;
            diag_end_in = range.start + bgcg_pkg::DIAG_BITS'(range.count);
            newline_in  = (chr_ff == bgcg_pkg::CHR_NEWLINE);
            unique case (chr_ff)
               bgcg_pkg::CHR_LETTER:
                  adv_in = narrow ? DB'(bgcg_pkg::NARROW_WIDTH + 1) :
                                    DB'(bgcg_pkg::WIDE_WIDTH + 1);
               bgcg_pkg::CHR_BANG, bgcg_pkg::CHR_DOT:
                  adv_in = DB'(bgcg_pkg::NARROW_WIDTH - 1);
               bgcg_pkg::CHR_QUEST:
                  adv_in = DB'(bgcg_pkg::NARROW_WIDTH + 1);
               bgcg_pkg::CHR_SPACE:
                  adv_in = DB'(1);
               default:
                  adv_in = '0;
            endcase
            if (sh_in != '0) begin
               state_in = bgcg_pkg::ST_SCAN;
            end else if (has_diag_in) begin
               state_in = bgcg_pkg::ST_DIAG;
            end else begin
               state_in = bgcg_pkg::ST_CURSOR;
            end
         end

         bgcg_pkg::ST_SCAN: begin
            unit_dx = DB'(col_ff);
            unit_dy = DB'(row_ff);
            // Dark cells advance without waiting on the response register
            if (!scan_bit || out_free) begin
               emit      = scan_bit;
               emit_last = rest_zero && !has_diag_ff;
               sh_in     = sh_ff << 1;
               if (col_ff == last_col_ff) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
               if (rest_zero) begin
                  state_in = has_diag_ff ? bgcg_pkg::ST_DIAG : bgcg_pkg::ST_CURSOR;
               end
            end
         end

         bgcg_pkg::ST_DIAG: begin
            unit_dx = DB'(piece.dx);
            unit_dy = DB'(piece.dy);
            if (out_free) begin
               emit        = 1'b1;
               emit_kind   = piece.kind;
               emit_last   = (diag_idx_ff + 1'b1 == diag_end_ff);
               diag_idx_in = diag_idx_ff + 1'b1;
               if (emit_last) begin
                  state_in = bgcg_pkg::ST_CURSOR;
               end
            end
         end

         bgcg_pkg::ST_CURSOR: begin
            unit_base_col = newline_ff ? '0 : cursor_col_ff;
            unit_dx       = newline_ff ? '0 : adv_ff;
            unit_dy       = newline_ff ? DB'(bgcg_pkg::LINE_HEIGHT) : '0;
            cursor_col_in = unit_sum_col;
            cursor_row_in = unit_sum_row;
            state_in      = bgcg_pkg::ST_IDLE;
         end

         default: begin
            state_in = bgcg_pkg::ST_IDLE;
         end
      endcase

      // Response register
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = unit_sum_col;
         rsp_y_in     = unit_sum_row;
         rsp_kind_in  = emit_kind;
         rsp_last_in  = emit_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign idle       = (state_ff == bgcg_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = bgcg_pkg::RSP_DATA_BITS'({rsp_kind_ff, rsp_y_ff, rsp_x_ff});
   assign rsp_tlast  = rsp_last_ff;

   // A cell that is not the last of its character keeps the sequencer busy
   a_mid_char_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |->
      (state_ff == bgcg_pkg::ST_SCAN || state_ff == bgcg_pkg::ST_DIAG))
      else $error("non-last cell pending while sequencer left the character");

   a_diag_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bgcg_pkg::ST_DIAG) |-> (diag_idx_ff < diag_end_ff))
      else $error("diagonal piece index ran past the letter's range");

   a_cursor_moves: assert property (@(posedge clock) disable iff (reset)
      (!$stable(cursor_col_ff) || !$stable(cursor_row_ff)) |->
      ($past(state_ff) == bgcg_pkg::ST_CURSOR || $past(req.restart)))
      else $error("cursor changed outside cursor update or restart");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      (req.start || req.restart) |-> (state_ff == bgcg_pkg::ST_IDLE))
      else $error("request handed to a busy sequencer");

endmodule

// ===== hw/rtl/bitmap_glyph_cell_generator_top.sv =====
// Top level of the bitmap glyph cell generator: request decode, glyph table, sequencer.
// Depends on bgcg_pkg, bgcg_ram and bgcg_seq.
//
// Usage
//   Requests arrive on req_* (tuser = command: load, draw, restart). A load
//   writes one glyph table slot, a restart puts the cursor at the origin; both give
//   no responses. A draw expands one character into lit unit cells, one response
//   per cell on rsp_*, tlast on the final cell.
//   After a draw request is taken, the table is read at the accepting edge,
//   the fetch state aligns the bitmap, then the scan steps through the bitmap
//   positions up to the last lit one (at most 20), then through the diagonal
//   pieces (at most 4), and the cursor state moves the cursor; each cell
//   goes through the shared saturating adder into the response register.
//   req_tready is high only while the sequencer is idle.
//   Reset clears the cursor and the table valid bits, so every slot reads as
//   zero until loaded; no clearing pass is needed.
//   A stalled receiver holds the response register; the scan waits on lit
//   cells while dark cells keep advancing. The last cell may still wait on
//   rsp_* while the next request is taken.

module bitmap_glyph_cell_generator_top (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata, low bit up: char_code[7:0], entry_index[12:8], entry_narrow[13],
   // entry_diag[14], entry_bitmap[34:15], zero pad
   input  logic [bgcg_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // tuser: command[1:0]
   input  logic [1:0]                          req_tuser,
   // Response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata, low bit up: cell_x[9:0], cell_y[19:10], cell_kind[21:20], zero pad
   output logic [bgcg_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                                rsp_tlast
);

   localparam int AB = bgcg_pkg::ADDR_BITS;

   logic       accept;
   logic       seq_idle;
   logic [7:0] req_char;
   logic [4:0] req_index;
   logic       req_narrow;
   logic       req_diag;
   logic [19:0] req_bitmap;
   bgcg_pkg::cmd_type req_cmd;

   logic                            wr_en;
   logic [AB-1:0]                   wr_addr;
   logic [bgcg_pkg::ENTRY_BITS-1:0] wr_data;
   logic [AB-1:0]                   rd_addr;
   logic [bgcg_pkg::ENTRY_BITS-1:0] rd_data;
   logic [bgcg_pkg::ENTRY_BITS-1:0] entry;

   logic [bgcg_pkg::TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic                             rd_valid_ff, rd_valid_in;

   bgcg_pkg::seq_req_type seq_req;
   bgcg_pkg::chr_type     chr;
   logic [4:0]            letter;
   logic [4:0]            slot;

   // Unpack the request payload
   assign req_char   = req_tdata[bgcg_pkg::REQ_CHAR_LO +: 8];
   assign req_index  = req_tdata[bgcg_pkg::REQ_INDEX_LO +: 5];
   assign req_narrow = req_tdata[bgcg_pkg::REQ_NARROW];
   assign req_diag   = req_tdata[bgcg_pkg::REQ_DIAG];
   assign req_bitmap = req_tdata[bgcg_pkg::REQ_BITMAP_LO +: 20];
   assign req_cmd    = bgcg_pkg::cmd_type'(req_tuser);

   assign req_tready = seq_idle;
   assign accept     = req_tvalid && req_tready;

   // Classify the character and pick its table slot; uppercase folds to lowercase
   always_comb begin
      chr    = bgcg_pkg::CHR_NONE;
      letter = '0;
      slot   = '0;
      priority if (req_char >= bgcg_pkg::CHAR_UPPER_A && req_char <= bgcg_pkg::CHAR_UPPER_Z) begin
         chr    = bgcg_pkg::CHR_LETTER;
         letter = 5'(req_char - bgcg_pkg::CHAR_UPPER_A);
         slot   = letter;
      end else if (req_char >= bgcg_pkg::CHAR_LOWER_A &&
                   req_char <= bgcg_pkg::CHAR_LOWER_Z) begin
         chr    = bgcg_pkg::CHR_LETTER;
         letter = 5'(req_char - bgcg_pkg::CHAR_LOWER_A);
         slot   = letter;
      end else if (req_char == bgcg_pkg::CHAR_BANG) begin
         chr  = bgcg_pkg::CHR_BANG;
         slot = bgcg_pkg::SLOT_BANG;
      end else if (req_char == bgcg_pkg::CHAR_DOT) begin
         chr  = bgcg_pkg::CHR_DOT;
         slot = bgcg_pkg::SLOT_DOT;
      end else if (req_char == bgcg_pkg::CHAR_QUEST) begin
         chr  = bgcg_pkg::CHR_QUEST;
         slot = bgcg_pkg::SLOT_QUEST;
      end else if (req_char == bgcg_pkg::CHAR_SPACE) begin
         chr = bgcg_pkg::CHR_SPACE;
      end else if (req_char == bgcg_pkg::CHAR_NEWLINE) begin
         chr = bgcg_pkg::CHR_NEWLINE;
      end else begin
         chr = bgcg_pkg::CHR_NONE;
      end
   end

   // Decode the command into table write and sequencer kick
   always_comb begin
      wr_en         = 1'b0;
      seq_req.start   = 1'b0;
      seq_req.restart = 1'b0;
      seq_req.chr     = chr;
      seq_req.letter  = letter;
      unique case (req_cmd)
         bgcg_pkg::CMD_LOAD:
            wr_en = accept && (32'(req_index) < bgcg_pkg::TABLE_DEPTH);
         bgcg_pkg::CMD_DRAW:
            seq_req.start = accept;
         bgcg_pkg::CMD_RESTART:
            seq_req.restart = accept;
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   assign wr_addr = AB'(req_index);
   assign wr_data = {req_narrow, req_diag, req_bitmap};
   assign rd_addr = AB'(slot);

   // Valid bits stand in for clearing the table at reset
   always_comb begin
      valid_in    = valid_ff;
      rd_valid_in = rd_valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      if (seq_req.start) begin
         rd_valid_in = valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= rd_valid_in;
   end

   bgcg_ram #(
      .WIDTH (bgcg_pkg::ENTRY_BITS),
      .DEPTH (bgcg_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (seq_req.start),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Never-loaded slots read as zero
   assign entry = rd_valid_ff ? rd_data : '0;

   bgcg_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req        (seq_req),
      .entry      (entry),
      .idle       (seq_idle),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== verif/bitmap_glyph_cell_generator_top_test.sv =====
// Self-checking testbench for bitmap_glyph_cell_generator_top: drives glyph loads, draws and
// restarts, predicts every lit cell and checks the response stream in order.
// Depends on bgcg_pkg and the bitmap_glyph_cell_generator_top RTL.

module bitmap_glyph_cell_generator_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bgcg_pkg::*;

   // Command code that the block must ignore
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int COORD_LIMIT  = (1 << COORD_BITS) - 1;
   localparam int HOLD_FROM    = 200;     // cycle after reset where the long sink stall starts
   localparam int HOLD_LEN     = 250;     // cycles the sink refuses cells
   localparam int DRAIN_CYCLES = 40;      // covers a full draw after the last expected cell
   localparam int RANDOM_REQS  = 194;     // random requests after the directed ones

   // One request as the stimulus sees it
   typedef struct {
      logic [1:0]  cmd;
      logic [7:0]  char_code;
      logic [4:0]  index;
      logic        narrow;
      logic        diag;
      logic [19:0] bitmap;
   } glyph_req_t;

   // One lit cell as it shows up on the response channel
   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      kind_type              kind;
      logic                  last;
   } cell_t;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [1:0]               req_tuser = CMD_LOAD;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tlast;

   glyph_req_t pending_reqs[$];
   cell_t      expected_cells[$];
   cell_t      draw_cells[$];

   // Predicted block state
   logic [ENTRY_BITS-1:0] glyph_entries [TABLE_DEPTH];
   logic [COORD_BITS-1:0] cur_col;
   logic [COORD_BITS-1:0] cur_row;

   int  mismatch_count = 0;
   int  req_gap = 0;
   int  rsp_stall = 0;
   int  run_cycles = 0;
   logic req_lazy = 1'b1;
   logic rsp_lazy = 1'b1;
   logic rsp_hold = 1'b0;

   bitmap_glyph_cell_generator_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------
   // Cell predictor
   // ------------------------------------------------------------------

   // Add a cursor offset, clamping at the top of the coordinate range.
   function automatic logic [COORD_BITS-1:0] sat_coord(input logic [COORD_BITS-1:0] base,
                                                       input int step);
      int sum;
      sum = int'(base) + step;
      if (sum > COORD_LIMIT) sum = COORD_LIMIT;
      return sum[COORD_BITS-1:0];
   endfunction

   function automatic void push_cell(input int dx, input int dy, input kind_type kind);
      cell_t c;
      c.x    = sat_coord(cur_col, dx);
      c.y    = sat_coord(cur_row, dy);
      c.kind = kind;
      c.last = 1'b0;
      draw_cells.push_back(c);
   endfunction

   // Walk the used bitmap bits from the top-left cell, row by row.
   function automatic void scan_glyph(input logic [19:0] bits, input int width);
      int cells;
      cells = width * GLYPH_ROWS;
      if (cells > MAX_SCAN) cells = MAX_SCAN;
      for (int k = 0; k < cells; k++) begin
         if (bits[cells-1-k]) push_cell(k % width, k / width, KIND_FULL);
      end
   endfunction

   // Update the predicted state for one accepted request and queue the cells it lights.
   function automatic void predict_cells(input logic [1:0] cmd,
                                         input logic [REQ_DATA_BITS-1:0] data);
      logic [7:0]            ch;
      logic [4:0]            slot;
      logic [ENTRY_BITS-1:0] entry;
      int                    width;
      ch = data[REQ_CHAR_LO +: 8];
      draw_cells.delete();
      case (cmd)
         CMD_LOAD: begin
            slot = data[REQ_INDEX_LO +: 5];
            if (int'(slot) < TABLE_DEPTH)
               glyph_entries[slot] = {data[REQ_NARROW], data[REQ_DIAG],
                                      data[REQ_BITMAP_LO +: 20]};
         end
         CMD_RESTART: begin
            cur_col = '0;
            cur_row = '0;
         end
         CMD_DRAW: begin
            // fold uppercase onto lowercase
            if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z)
               ch = ch + (CHAR_LOWER_A - CHAR_UPPER_A);
            if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
               entry = glyph_entries[ch - CHAR_LOWER_A];
               width = entry[ENTRY_NARROW] ? NARROW_WIDTH : WIDE_WIDTH;
               scan_glyph(entry[19:0], width);
               if (entry[ENTRY_DIAG]) begin
                  case (ch)
                     "b", "d", "p": push_cell(2, 0, KIND_LL);
                     "g": push_cell(2, 2, KIND_LL);
                     "j": push_cell(0, 4, KIND_UR);
                     "k", "r": begin
                        push_cell(2, 3, KIND_LL);
                        push_cell(1, 3, KIND_UR);
                     end
                     "n": begin
                        push_cell(1, 0, KIND_LL);
                        push_cell(1, 1, KIND_UR);
                        push_cell(2, 1, KIND_LL);
                        push_cell(2, 2, KIND_UR);
                     end
                     "q": begin
                        push_cell(2, 0, KIND_LL);
                        push_cell(0, 4, KIND_UR);
                     end
                     "s": begin
                        push_cell(1, 1, KIND_LL);
                        push_cell(0, 2, KIND_UR);
                        push_cell(2, 2, KIND_LL);
                        push_cell(1, 3, KIND_UR);
                     end
                     default: ;
                  endcase
               end
               cur_col = sat_coord(cur_col, width + 1);
            end else if (ch == CHAR_SPACE) begin
               cur_col = sat_coord(cur_col, 1);
            end else if (ch == CHAR_NEWLINE) begin
               cur_col = '0;
               cur_row = sat_coord(cur_row, LINE_HEIGHT);
            end else if (ch == CHAR_BANG || ch == CHAR_DOT || ch == CHAR_QUEST) begin
               // punctuation is always narrow; its entry flags do not matter
               slot = (ch == CHAR_BANG) ? SLOT_BANG :
                      (ch == CHAR_DOT) ? SLOT_DOT : SLOT_QUEST;
               scan_glyph(glyph_entries[slot][19:0], NARROW_WIDTH);
               if (ch == CHAR_QUEST) cur_col = sat_coord(cur_col, NARROW_WIDTH + 1);
               else cur_col = sat_coord(cur_col, NARROW_WIDTH - 1);
            end
         end
         default: ;
      endcase
      if (draw_cells.size() > 0) draw_cells[draw_cells.size()-1].last = 1'b1;
      foreach (draw_cells[i]) expected_cells.push_back(draw_cells[i]);
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic glyph_req_t make_req(input logic [1:0] cmd, input logic [7:0] ch,
                                           input logic [4:0] index, input logic narrow,
                                           input logic diag, input logic [19:0] bitmap);
      glyph_req_t r;
      r.cmd       = cmd;
      r.char_code = ch;
      r.index     = index;
      r.narrow    = narrow;
      r.diag      = diag;
      r.bitmap    = bitmap;
      return r;
   endfunction

   // Mostly fully random bitmaps, with empty, full and single-cell ones mixed in.
   function automatic logic [19:0] random_bitmap();
      logic [31:0] rnd;
      int          pick;
      rnd  = $urandom;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 20'h0;
      if (pick == 1) return 20'hFFFFF;
      if (pick == 2) return 20'h1 << $urandom_range(0, 19);
      return rnd[19:0];
   endfunction

   // Letters in both cases dominate; the rest is punctuation, spacing and junk codes.
   function automatic logic [7:0] random_char();
      logic [31:0] rnd;
      int          pick;
      int          letter;
      rnd    = $urandom;
      pick   = $urandom_range(0, 99);
      letter = $urandom_range(0, 25);
      if (pick < 70) return (rnd[8] ? CHAR_UPPER_A : CHAR_LOWER_A) + letter[7:0];
      if (pick < 80) return (rnd[1:0] == 2'd0) ? CHAR_BANG :
                            (rnd[1:0] == 2'd1) ? CHAR_DOT : CHAR_QUEST;
      if (pick < 88) return CHAR_SPACE;
      if (pick < 93) return CHAR_NEWLINE;
      return rnd[7:0];
   endfunction

   // Random request; fields the command does not use carry noise.
   function automatic glyph_req_t random_request();
      glyph_req_t  r;
      logic [31:0] rnd;
      int          pick;
      rnd  = $urandom;
      pick = $urandom_range(0, 99);
      r = make_req(CMD_DRAW, rnd[7:0], rnd[12:8], rnd[13], rnd[14], random_bitmap());
      if (pick < 25) r.cmd = CMD_LOAD;
      else if (pick < 90) r.char_code = random_char();
      else if (pick < 95) r.cmd = CMD_RESTART;
      else r.cmd = CMD_UNUSED;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Request driver: present queued requests, hold until taken, sometimes idle between
   // ------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      glyph_req_t               next_req;
      logic [REQ_DATA_BITS-1:0] payload;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_gap > 0) begin
            req_tvalid <= 1'b0;
            req_gap    <= req_gap - 1;
         end else if (pending_reqs.size() > 0) begin
            next_req = pending_reqs.pop_front();
            payload  = '0;
            payload[REQ_CHAR_LO +: 8]    = next_req.char_code;
            payload[REQ_INDEX_LO +: 5]   = next_req.index;
            payload[REQ_NARROW]          = next_req.narrow;
            payload[REQ_DIAG]            = next_req.diag;
            payload[REQ_BITMAP_LO +: 20] = next_req.bitmap;
            req_tdata  <= payload;
            req_tuser  <= next_req.cmd;
            req_tvalid <= 1'b1;
            // flip between idle-heavy and back-to-back stretches now and then
            if ($urandom_range(0, 15) == 0) req_lazy <= !req_lazy;
            req_gap <= req_lazy ? $urandom_range(0, 3) : 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Long sink stall: count cycles after reset and block the sink for a while
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         run_cycles <= 0;
         rsp_hold   <= 1'b0;
      end else begin
         run_cycles <= run_cycles + 1;
         rsp_hold   <= (run_cycles >= HOLD_FROM) && (run_cycles < HOLD_FROM + HOLD_LEN);
      end
   end

   // ------------------------------------------------------------------
   // Response sink: in lazy stretches, may drop tready after a taken cell and count down the stall cycles
   // ------------------------------------------------------------------
   always @(posedge clock) begin : rsp_sink
      int stall;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else if (rsp_hold) begin
         rsp_tready <= 1'b0;
      end else if (rsp_tready) begin
         if (rsp_tvalid) begin
            if ($urandom_range(0, 15) == 0) rsp_lazy <= !rsp_lazy;
            stall = rsp_lazy ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               rsp_stall  <= stall - 1;
            end
         end
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Monitor: check each taken cell against the oldest prediction, then
   // predict the cells of any request taken at this edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin : cell_monitor
      cell_t got;
      cell_t want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.x    = rsp_tdata[COORD_BITS-1:0];
            got.y    = rsp_tdata[2*COORD_BITS-1:COORD_BITS];
            got.kind = kind_type'(rsp_tdata[2*COORD_BITS +: 2]);
            got.last = rsp_tlast;
            if (expected_cells.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected cell x=%0d y=%0d kind=%0d last=%0b",
                           $realtime, got.x, got.y, got.kind, got.last);
            end else begin
               want = expected_cells.pop_front();
               if (got != want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display(
                        "%0t: expected x=%0d y=%0d k=%0d l=%0b, got x=%0d y=%0d k=%0d l=%0b",
                        $realtime, want.x, want.y, want.kind, want.last,
                        got.x, got.y, got.kind, got.last);
               end
            end
         end
         if (req_tvalid && req_tready) predict_cells(req_tuser, req_tdata);
      end
   end

   // ------------------------------------------------------------------
   // Stimulus, reset and end of run
   // ------------------------------------------------------------------
   initial begin : stimulus
      foreach (glyph_entries[i]) glyph_entries[i] = '0;
      cur_col = '0;
      cur_row = '0;

      // Directed: empty table, full glyphs, the n, s and j diagonal shapes, punctuation,
      // spacing, junk codes, the unused command and restart.
      pending_reqs.push_back(make_req(CMD_DRAW, CHAR_LOWER_A, 5'd0, 1'b0, 1'b0, 20'h0));
      pending_reqs.push_back(make_req(CMD_DRAW, CHAR_BANG, 5'd31, 1'b1, 1'b1, 20'hFFFFF));
      pending_reqs.push_back(make_req(CMD_LOAD, 8'hFF, 5'd0, 1'b0, 1'b1, 20'hFFFFF));
      pending_reqs.push_back(make_req(CMD_DRAW, CHAR_UPPER_A, 5'd0, 1'b0, 1'b0, 20'h0));
      pending_reqs.push_back(make_req(CMD_LOAD, 8'h00, LTR_N, 1'b1, 1'b1, 20'hFFFFF));
      pending_reqs.push_back(make_req(CMD_DRAW, "n", 5'd0, 1'b0, 1'b0, 20'h0));
      pending_reqs.push_back(make_req(CMD_LOAD, 8'h00, LTR_S, 1'b0, 1'b1, 20'hFFFFF));
      pending_reqs.push_back(make_req(CMD_DRAW, "S", 5'd0, 1'b0, 1'b0, 20'h0));
      pending_reqs.push_back(make_req(CMD_LOAD, 8'h00, SLOT_BANG, 1'b0, 1'b1, 20'hA5555));
      pending_reqs.push_back(make_req(CMD_LOAD, 8'h00, SLOT_DOT, 1'b1, 1'b0, 20'h00001));
      pending_reqs.push_back(make_req(CMD_LOAD, 8'h00, SLOT_QUEST, 1'b0, 1'b0, 20'h04000));
      pending_reqs.push_back(make_req(CMD_DRAW, CHAR_BANG, 5'd0, 1'b0, 1'b0, 20'h0));
      pending_reqs.push_back(make_req(CMD_DRAW, CHAR_DOT, 5'd0, 1'b0, 1'b0, 20'h0));
      pending_reqs.push_back(make_req(CMD_DRAW, CHAR_QUEST, 5'd0, 1'b0, 1'b0, 20'h0));
      pending_reqs.push_back(make_req(CMD_LOAD, 8'h00, 5'd31, 1'b1, 1'b1, 20'hFFFFF));
      pending_reqs.push_back(make_req(CMD_LOAD, 8'h00, 5'd29, 1'b0, 1'b0, 20'h12345));
      pending_reqs.push_back(make_req(CMD_DRAW, CHAR_SPACE, 5'd0, 1'b0, 1'b0, 20'h0));
      pending_reqs.push_back(make_req(CMD_DRAW, CHAR_NEWLINE, 5'd0, 1'b0, 1'b0, 20'h0));
      pending_reqs.push_back(make_req(CMD_DRAW, 8'hFF, 5'd31, 1'b1, 1'b1, 20'hFFFFF));
      pending_reqs.push_back(make_req(CMD_DRAW, 8'h00, 5'd0, 1'b0, 1'b0, 20'h0));
      pending_reqs.push_back(make_req(CMD_UNUSED, CHAR_UPPER_A, 5'd0, 1'b1, 1'b1, 20'hFFFFF));
      // empty bitmap with diagonals: only the slanted cell lights
      pending_reqs.push_back(make_req(CMD_LOAD, 8'h00, LTR_J, 1'b0, 1'b1, 20'h0));
      pending_reqs.push_back(make_req(CMD_DRAW, "j", 5'd0, 1'b0, 1'b0, 20'h0));
      // narrow glyph ignores the bits above its 15 cells
      pending_reqs.push_back(make_req(CMD_LOAD, 8'h00, LTR_K, 1'b1, 1'b0, 20'hF8000));
      pending_reqs.push_back(make_req(CMD_DRAW, "k", 5'd0, 1'b0, 1'b0, 20'h0));
      pending_reqs.push_back(make_req(CMD_RESTART, 8'h00, 5'd0, 1'b0, 1'b0, 20'h0));

      // Random traffic
      repeat (RANDOM_REQS) pending_reqs.push_back(random_request());

      // Hold reset, then release it once
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Wait until every request is taken and every predicted cell is seen
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || expected_cells.size() != 0);

      // Let a possible late or extra cell show up
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_cells.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

endmodule
